### hdl/brcf_pkg.sv
// ----------------------------------------------------------------------------
// brcf_pkg: shared definitions for the byte ring chunk FIFO
// Sizes, request and status codes used by the ring control and its store.
// ----------------------------------------------------------------------------
package brcf_pkg;

  localparam int DEPTH   = 1024;
  localparam int MAX_GET = 64;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CAP_W   = $clog2(DEPTH + 1);
  localparam int GRANT_W = $clog2(MAX_GET + 1);

  localparam int REQ_W    = 2;
  localparam int COUNT_W  = 10;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [DATA_W-1:0]   byte_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CAP_W-1:0]    cap_t;
  typedef logic [GRANT_W-1:0]  grant_t;

  localparam req_t REQ_PUT   = 2'd0;
  localparam req_t REQ_GET   = 2'd1;
  localparam req_t REQ_CLEAR = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam cap_t CAP_MIN   = cap_t'(2);
  localparam cap_t CAP_DEPTH = cap_t'(DEPTH);
  localparam count_t MAX_GET_CNT = count_t'(MAX_GET);

endpackage

### hdl/brcf_ram.sv
// ----------------------------------------------------------------------------
// brcf_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module brcf_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/byte_ring_chunk_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_chunk_fifo: circular byte FIFO with chunked puts
// Ring control around a single byte store with registered read data.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a word is taken at a rising edge with start high and busy
//   low. Put words stream one byte each; the first word of a chunk carries
//   the chunk length and decides acceptance of the whole chunk. A get word
//   asks for up to MAX_GET bytes; a clear word empties the ring.
//   Result channel: each result word sits on the out_ ports for exactly one
//   cycle with out_valid high. The receiver cannot stall; it must take it.
//   Results: the first result of any word appears in the cycle after accept.
//   Flow: put, clear and single-result words do not raise busy. A get
//   granting n bytes reads one byte per cycle from the store through its
//   single read port; busy stays high, and no new word is taken, meanwhile.
//   Configuration: cfg_capacity is written when cfg_valid and cfg_ready are
//   high; cfg_ready is low during a get and while start is high, so a
//   command word always wins. The write empties the ring.
//   Reset (rst_n low, synchronous) empties the ring, ends any chunk and
//   sets the capacity to the full store. The store itself is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_chunk_fifo (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  brcf_pkg::req_t     in_req_type,
  input  logic               in_chunk_first,
  input  brcf_pkg::count_t   in_byte_count,
  input  brcf_pkg::byte_t    in_data_in,
  // result channel
  output logic               out_valid,
  output brcf_pkg::status_t  out_status,
  output brcf_pkg::byte_t    out_data_out,
  output logic               out_data_valid,
  output brcf_pkg::count_t   out_granted_count,
  output logic               out_last_result,
  output logic               out_buffer_empty,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  brcf_pkg::cap_t     cfg_capacity
);

  import brcf_pkg::*;

  // control state
  cap_t   cap_r,       cap_nxt;
  addr_t  head_r,      head_nxt;
  addr_t  tail_r,      tail_nxt;
  count_t chunk_rem_r, chunk_rem_nxt;
  logic   chunk_acc_r, chunk_acc_nxt;
  grant_t get_left_r,  get_left_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_rd_r,    out_rd_nxt;

  // result payload
  status_t out_status_r,  out_status_nxt;
  count_t  out_granted_r, out_granted_nxt;
  logic    out_last_r,    out_last_nxt;
  logic    out_empty_r,   out_empty_nxt;

  // store ports
  logic  ram_we;
  byte_t ram_wdata;
  logic  ram_re;
  byte_t ram_rdata;

  // ring arithmetic
  cap_t   diff;
  cap_t   have;
  cap_t   free_sp;
  cap_t   tail_inc;
  cap_t   head_inc;
  addr_t  tail_adv;
  addr_t  head_adv;
  logic   ring_full;
  grant_t req_cap;
  grant_t grant;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    // count stored bytes: (tail - head) mod cap
    diff     = {1'b0, tail_r} - {1'b0, head_r};
    have     = diff[CAP_W-1] ? diff + cap_r : diff;
    free_sp  = cap_r - cap_t'(1) - have;
    tail_inc = {1'b0, tail_r} + cap_t'(1);
    head_inc = {1'b0, head_r} + cap_t'(1);
    tail_adv = (tail_inc == cap_r) ? '0 : tail_inc[ADDR_W-1:0];
    head_adv = (head_inc == cap_r) ? '0 : head_inc[ADDR_W-1:0];
    ring_full = (tail_adv == head_r);
    // grant = min(request, MAX_GET, stored)
    req_cap = (in_byte_count > MAX_GET_CNT) ? grant_t'(MAX_GET)
                                            : in_byte_count[GRANT_W-1:0];
    grant   = (cap_t'(req_cap) > have) ? have[GRANT_W-1:0] : req_cap;
  end

  always_comb begin
    cap_nxt         = cap_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    chunk_rem_nxt   = chunk_rem_r;
    chunk_acc_nxt   = chunk_acc_r;
    get_left_nxt    = get_left_r;
    out_valid_nxt   = 1'b0;
    out_rd_nxt      = 1'b0;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_last_nxt    = out_last_r;
    out_empty_nxt   = out_empty_r;
    ram_we          = 1'b0;
    ram_wdata       = in_data_in;
    ram_re          = 1'b0;

    if (cfg_valid && cfg_ready) begin
      // clamp capacity to 2..DEPTH, empty the ring, drop the chunk
      if (cfg_capacity < CAP_MIN) begin
        cap_nxt = CAP_MIN;
      end else if (cfg_capacity > CAP_DEPTH) begin
        cap_nxt = CAP_DEPTH;
      end else begin
        cap_nxt = cfg_capacity;
      end
      head_nxt      = '0;
      tail_nxt      = '0;
      chunk_rem_nxt = '0;
      chunk_acc_nxt = 1'b0;
    end else if (accept) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = ST_OK;
      out_granted_nxt = '0;
      out_last_nxt    = 1'b1;
      out_empty_nxt   = (head_r == tail_r);
      unique case (in_req_type)
        REQ_PUT: begin
          if (in_chunk_first) begin
            chunk_rem_nxt = (in_byte_count != '0) ? in_byte_count - count_t'(1) : '0;
            if (cap_t'(in_byte_count) > free_sp) begin
              // whole chunk rejected
              chunk_acc_nxt  = 1'b0;
              out_status_nxt = ST_FULL;
            end else begin
              chunk_acc_nxt   = 1'b1;
              out_granted_nxt = in_byte_count;
              if (in_byte_count != '0) begin
                if (ring_full) begin
                  out_status_nxt = ST_FULL;
                end else begin
                  ram_we   = 1'b1;
                  tail_nxt = tail_adv;
                end
              end
            end
          end else if (chunk_rem_r != '0) begin
            chunk_rem_nxt = chunk_rem_r - count_t'(1);
            if (!chunk_acc_r || ring_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              ram_we   = 1'b1;
              tail_nxt = tail_adv;
            end
          end
          // stray byte outside a chunk: ignore, report ok
          out_empty_nxt = (tail_nxt == head_r);
        end
        REQ_GET: begin
          if (grant == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            // read the first byte now, the rest while busy
            ram_re          = 1'b1;
            head_nxt        = head_adv;
            get_left_nxt    = grant - grant_t'(1);
            out_rd_nxt      = 1'b1;
            out_granted_nxt = count_t'(grant);
            out_last_nxt    = (grant == grant_t'(1));
            out_empty_nxt   = (cap_t'(grant) == have);
          end
        end
        REQ_CLEAR: begin
          tail_nxt      = head_r;
          out_empty_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (busy) begin
      // advance the get: one store read per cycle
      ram_re        = 1'b1;
      head_nxt      = head_adv;
      get_left_nxt  = get_left_r - grant_t'(1);
      out_valid_nxt = 1'b1;
      out_rd_nxt    = 1'b1;
      out_last_nxt  = (get_left_r == grant_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_DEPTH;
      head_r      <= '0;
      tail_r      <= '0;
      chunk_rem_r <= '0;
      chunk_acc_r <= 1'b0;
      get_left_r  <= '0;
      out_valid_r <= 1'b0;
      out_rd_r    <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      chunk_rem_r <= chunk_rem_nxt;
      chunk_acc_r <= chunk_acc_nxt;
      get_left_r  <= get_left_nxt;
      out_valid_r <= out_valid_nxt;
      out_rd_r    <= out_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_last_r    <= out_last_nxt;
    out_empty_r   <= out_empty_nxt;
  end

  brcf_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign busy              = (get_left_r != '0);
  assign cfg_ready         = !busy && !start;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_data_out      = out_rd_r ? ram_rdata : '0;
  assign out_data_valid    = out_rd_r;
  assign out_granted_count = out_granted_r;
  assign out_last_result   = out_last_r;
  assign out_buffer_empty  = out_empty_r;

`ifndef NO_ASSERTIONS
  // every busy cycle reads one byte and yields a result next cycle
  a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("get cycle produced no result");

  // a non-final result means the get is still running
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |-> busy)
    else $error("non-final result without a running get");

  // data results always report ok
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_valid) |-> (out_status == ST_OK))
    else $error("data result with bad status");

  // pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, head_r} < cap_r) && ({1'b0, tail_r} < cap_r))
    else $error("ring pointer beyond capacity");
`endif

endmodule
